[rtl/assert_macros.svh]
// Assertion helpers for the point decimator.
// The using module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every clock edge, also while reset is applied.
`define DCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dcd_pkg.sv]
`default_nettype none

package dcd_pkg;

	// Q12.4 coordinates
	localparam int unsigned COORD_FRAC_BITS      = 4;
	localparam int unsigned MAX_CHAIN_POINTS_DFLT = 4096;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned STAB_W  = 11;
	localparam int unsigned GRAD_W  = 16;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned ACC_W   = 17;

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// square root of dx^2 + dy^2: 33-bit radicand padded to an even width
	localparam int unsigned RAD_W  = 34;
	localparam int unsigned ROOT_W = RAD_W / 2;
	localparam int unsigned REM_W  = ROOT_W + 2;

	// config port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [0:0] {
		REG_SPACING = 1'b0
	} reg_idx_t;

	localparam logic [COORD_W-1:0] SPACING_RESET = 16'd48;
	localparam logic [COORD_W-1:0] SPACING_ONE   = COORD_W'(1 << COORD_FRAC_BITS);

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               is_stable;
		logic               is_corner;
		logic [STAB_W-1:0]  stability;
		logic [GRAD_W-1:0]  grad_mag;
		logic [IDX_W-1:0]   point_index;
		logic               chain_end;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]   kept_index;
		logic [COORD_W-1:0] kept_x;
		logic [COORD_W-1:0] kept_y;
		logic [IDX_W-1:0]   out_seq;
		logic               last_of_chain;
	} out_t;

endpackage

`default_nettype wire

[rtl/edge_chain_point_decimator_unit.sv]
`default_nettype none

// Edge chain point decimator. Takes one edge point per beat on the point
// channel and thins the chain: unstable points are dropped, stable points are
// kept on the first keep of a chain, on a corner, or once the summed distance
// since the last keep reaches spacing_q4 (Q12.4, values below 1.0 act as 1.0).
// A point close to the held one (under half the spacing) that is more stable
// or has a >1.15x stronger gradient replaces it. Kept points leave one keep
// late on the kept channel with a renumbered out_seq; chain_end flushes the
// held point with last_of_chain set, so one point can yield 0, 1 or 2 beats.
// One point at a time: a point that needs a distance goes through squaring of
// dx, then of dy, then the 2-bit-per-cycle square root of dx^2+dy^2 (17 steps
// plus handoff), then decide, update and flush steps; a point with nothing
// held or not stable goes straight to the decide step. A full two-entry output queue
// stalls the update or flush step until the sink takes a beat. spacing_q4
// sits at byte address 0 of the APB port and resets to 3.0 pixels.
module edge_chain_point_decimator_unit #(
	parameter int unsigned MAX_CHAIN_POINTS = dcd_pkg::MAX_CHAIN_POINTS_DFLT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// point input
	input  wire                           point_valid,
	output logic                          point_ready,
	input  wire dcd_pkg::in_t             point,
	// kept output
	output logic                          kept_valid,
	input  wire                           kept_ready,
	output dcd_pkg::out_t                 kept,
	// APB config
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [dcd_pkg::PADDR_W-1:0]   paddr,
	input  wire  [dcd_pkg::PDATA_W-1:0]   pwdata,
	output logic [dcd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import dcd_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned CNT_W = $clog2(MAX_CHAIN_POINTS);
	localparam int unsigned MUL_W = 2 * COORD_W;
	localparam int unsigned G_W   = GRAD_W + 5;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SQX    = 7'b0000010,
		S_SQY    = 7'b0000100,
		S_ROOT   = 7'b0001000,
		S_DECIDE = 7'b0010000,
		S_OLD    = 7'b0100000,
		S_END    = 7'b1000000
	} state_t;

	state_t state_q;

	// config
	logic [COORD_W-1:0] spacing_q;
	logic [COORD_W-1:0] spacing_eff;
	logic               cfg_wr;

	// current item
	in_t                item_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [MUL_W-1:0]   sqx_q;
	logic [MUL_W-1:0]   sqy;

	// held point and chain state
	logic [COORD_W-1:0] held_x_q;
	logic [COORD_W-1:0] held_y_q;
	logic [STAB_W-1:0]  held_stab_q;
	logic [GRAD_W-1:0]  held_grad_q;
	logic [IDX_W-1:0]   held_index_q;
	logic               has_held_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   out_count_q;
	logic [CNT_W-1:0]   out_count_nxt;

	// decision
	logic               keep_q;
	logic               replace_q;
	logic [ACC_W-1:0]   acc_new_q;

	// root unit
	logic               sq_start;
	logic [RAD_W-1:0]   sq_rad;
	logic               sq_done;
	logic [ROOT_W-1:0]  sq_root;

	// result queue
	logic               fifo_push;
	logic               fifo_room;
	out_t               fifo_data;

	logic               accept;
	logic               measure;

	// -------------------------------------------------------------------
	// Config port
	// -------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_wr && (reg_idx_t'(paddr[PADDR_W-1]) == REG_SPACING)) begin
			spacing_q <= pwdata[COORD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx_t'(paddr[PADDR_W-1]) == REG_SPACING) begin
			prdata = PDATA_W'(spacing_q);
		end
	end

	assign spacing_eff = (spacing_q < SPACING_ONE) ? SPACING_ONE : spacing_q;

	// -------------------------------------------------------------------
	// Intake
	// -------------------------------------------------------------------
	assign point_ready = (state_q == S_IDLE);
	assign accept      = point_valid && point_ready;
	// a distance is only needed for a stable point with something held
	assign measure     = point.is_stable && has_held_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= point;
			dx_q   <= (point.pos_x > held_x_q) ? point.pos_x - held_x_q
			                                   : held_x_q - point.pos_x;
			dy_q   <= (point.pos_y > held_y_q) ? point.pos_y - held_y_q
			                                   : held_y_q - point.pos_y;
		end
		if (state_q == S_SQX) begin
			sqx_q <= dx_q * dx_q;
		end
	end

	// -------------------------------------------------------------------
	// Distance: dy^2 joins dx^2 on the way into the root unit
	// -------------------------------------------------------------------
	assign sq_start = (state_q == S_SQY);
	assign sqy      = dy_q * dy_q;
	assign sq_rad   = RAD_W'(sqx_q) + RAD_W'(sqy);

	dcd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	// -------------------------------------------------------------------
	// Keep / replace decision
	// -------------------------------------------------------------------
	logic [ACC_W-1:0] d_w;
	logic [ACC_W:0]   acc_sum;
	logic [ACC_W-1:0] acc_sat;
	logic [ACC_W:0]   d_x2;
	logic [G_W-1:0]   g20;
	logic [G_W-1:0]   h23;
	logic             stable_held;
	logic             keep_w;
	logic             replace_w;

	always_comb begin
		stable_held = item_q.is_stable && has_held_q;
		d_w         = stable_held ? sq_root : '0;
		acc_sum     = (ACC_W+1)'(acc_q) + (ACC_W+1)'(d_w);
		acc_sat     = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
		d_x2        = {d_w, 1'b0};
		// 20*g versus 23*h, shift-and-add
		g20 = (G_W'(item_q.grad_mag) << 4) + (G_W'(item_q.grad_mag) << 2);
		h23 = (G_W'(held_grad_q) << 4) + (G_W'(held_grad_q) << 2)
		    + (G_W'(held_grad_q) << 1) + G_W'(held_grad_q);
		keep_w = item_q.is_stable
		      && (!has_held_q || (acc_sat >= ACC_W'(spacing_eff)) || item_q.is_corner);
		replace_w = stable_held && !keep_w
		         && (d_x2 < (ACC_W+1)'(spacing_eff))
		         && ((item_q.stability > held_stab_q) || (g20 > h23));
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			keep_q    <= keep_w;
			replace_q <= replace_w;
			acc_new_q <= stable_held ? acc_sat : acc_q;
		end
	end

	// -------------------------------------------------------------------
	// Emission into the result queue
	// -------------------------------------------------------------------
	logic emit_old;
	logic emit_last;

	assign emit_old  = (state_q == S_OLD) && keep_q && has_held_q;
	assign emit_last = (state_q == S_END) && item_q.chain_end && has_held_q;
	assign fifo_push = (emit_old || emit_last) && fifo_room;

	assign out_count_nxt = (out_count_q == CNT_W'(MAX_CHAIN_POINTS - 1))
	                       ? '0 : out_count_q + 1'b1;

	always_comb begin
		fifo_data.kept_index    = held_index_q;
		fifo_data.kept_x        = held_x_q;
		fifo_data.kept_y        = held_y_q;
		fifo_data.out_seq       = IDX_W'(out_count_q);
		fifo_data.last_of_chain = emit_last;
	end

	dcd_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fifo_push),
		.push_data  (fifo_data),
		.room       (fifo_room),
		.kept       (kept),
		.kept_valid (kept_valid),
		.kept_ready (kept_ready)
	);

	// -------------------------------------------------------------------
	// Held point payload (updated once the old one has left)
	// -------------------------------------------------------------------
	logic load_held;

	assign load_held = (state_q == S_OLD) && (keep_q || replace_q)
	                && (!emit_old || fifo_room);

	always_ff @(posedge clk) begin
		if (load_held) begin
			held_x_q     <= item_q.pos_x;
			held_y_q     <= item_q.pos_y;
			held_stab_q  <= item_q.stability;
			held_grad_q  <= item_q.grad_mag;
			held_index_q <= item_q.point_index;
		end
	end

	// -------------------------------------------------------------------
	// Sequencer and chain state
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			has_held_q  <= 1'b0;
			acc_q       <= '0;
			out_count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= measure ? S_SQX : S_DECIDE;
					end
				end
				S_SQX: begin
					state_q <= S_SQY;
				end
				S_SQY: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					if (!emit_old || fifo_room) begin
						if (emit_old) begin
							out_count_q <= out_count_nxt;
						end
						if (keep_q) begin
							has_held_q <= 1'b1;
							acc_q      <= '0;
						end else begin
							acc_q <= acc_new_q;
						end
						state_q <= S_END;
					end
				end
				S_END: begin
					if (!emit_last || fifo_room) begin
						if (item_q.chain_end) begin
							has_held_q  <= 1'b0;
							acc_q       <= '0;
							out_count_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// -------------------------------------------------------------------
	// Checks
	// -------------------------------------------------------------------
	`DCD_ASSERT(a_acc_clear_when_empty, !has_held_q |-> (acc_q == '0), "distance sum nonzero with nothing held")
	`DCD_ASSERT(a_push_has_room, fifo_push |-> fifo_room, "result queue overflow")
	`DCD_ASSERT(a_root_in_root_state, sq_done |-> (state_q == S_ROOT), "root finished outside root wait")
	`DCD_ASSERT_ALWAYS(a_no_intake_while_busy, (state_q != S_IDLE) |-> !point_ready, "point taken while busy")

endmodule

`default_nettype wire

[rtl/dcd_isqrt.sv]
`default_nettype none

// Floor square root, two radicand bits per cycle, one root bit per step.
module dcd_isqrt (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [dcd_pkg::RAD_W-1:0]   rad,
	output logic                        done,
	output logic [dcd_pkg::ROOT_W-1:0]  root
);
	import dcd_pkg::*;

	localparam int unsigned CNT_W = $clog2(ROOT_W);
	localparam int unsigned CUR_W = REM_W + 2;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CUR_W-1:0] cur;
	logic [CUR_W-1:0] trial;
	logic             ge;
	logic [CUR_W-1:0] diff;

	always_comb begin
		cur   = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = (cur >= trial);
		diff  = cur - trial;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last step
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

[rtl/dcd_out_fifo.sv]
`default_nettype none

// Two-entry result queue; parts the decimator from the output handshake.
module dcd_out_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire dcd_pkg::out_t  push_data,
	output logic                room,
	output dcd_pkg::out_t       kept,
	output logic                kept_valid,
	input  wire                 kept_ready
);
	import dcd_pkg::*;

	out_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign room       = (cnt_q != 2'd2);
	assign kept_valid = (cnt_q != 2'd0);
	assign kept       = mem_q[rd_ptr_q];
	assign pop        = kept_valid && kept_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
	import dcd_pkg::*;

	// no beat on any port for this long means the block has hung
	localparam int unsigned STALL_LIMIT = 1000;
	// margin for the slowest point plus queue handoff; used before config writes and at the end
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned ACC_CEIL = 131071;
	localparam int unsigned SEQ_WRAP = MAX_CHAIN_POINTS_DFLT;
	localparam int unsigned IN_W = $bits(in_t);
	localparam int unsigned RANDOM_PER_PHASE = 180;

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_ready;
	in_t point;
	logic kept_valid;
	logic kept_ready;
	out_t kept;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	edge_chain_point_decimator_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point       (point),
		.kept_valid  (kept_valid),
		.kept_ready  (kept_ready),
		.kept        (kept),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Decimator shadow: held point, distance sum, output numbering
	// ---------------------------------------------------------------
	logic [COORD_W-1:0] held_x;
	logic [COORD_W-1:0] held_y;
	logic [STAB_W-1:0]  held_stab;
	logic [GRAD_W-1:0]  held_grad;
	logic [IDX_W-1:0]   held_idx;
	bit                 held_live;
	int unsigned        dist_sum;
	int unsigned        seq_count;
	logic [COORD_W-1:0] spacing_reg;

	// beats produced by the latest point (0, 1 or 2)
	out_t fresh_kept [2];
	int   fresh_n;

	// kept beats still owed by the block, oldest first
	out_t pending_kept [$];

	int errors;
	bit snd_calm;
	bit rcv_calm;

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned eff_spacing();
		return (spacing_reg < SPACING_ONE) ? int'(SPACING_ONE) : int'(spacing_reg);
	endfunction

	// append one owed beat at the tail
	task automatic owe_beat(input out_t r);
		pending_kept.insert(pending_kept.size(), r);
	endtask

	task automatic emit_held(input bit last);
		fresh_kept[fresh_n].kept_index    = held_idx;
		fresh_kept[fresh_n].kept_x        = held_x;
		fresh_kept[fresh_n].kept_y        = held_y;
		fresh_kept[fresh_n].out_seq       = seq_count[IDX_W-1:0];
		fresh_kept[fresh_n].last_of_chain = last;
		fresh_n++;
		seq_count = (seq_count + 1 >= SEQ_WRAP) ? 0 : seq_count + 1;
	endtask

	task automatic hold_point(input in_t p);
		held_x    = p.pos_x;
		held_y    = p.pos_y;
		held_stab = p.stability;
		held_grad = p.grad_mag;
		held_idx  = p.point_index;
	endtask

	// advance the shadow by one accepted point; results land in fresh_kept
	task automatic thin_point(input in_t p);
		longint unsigned dx;
		longint unsigned dy;
		int unsigned d;
		int unsigned spc;
		spc = eff_spacing();
		fresh_n = 0;
		if (p.is_stable) begin
			d = 0;
			if (held_live) begin
				dx = (p.pos_x > held_x) ? p.pos_x - held_x : held_x - p.pos_x;
				dy = (p.pos_y > held_y) ? p.pos_y - held_y : held_y - p.pos_y;
				d = int'(floor_root(dx * dx + dy * dy));
				// accumulator saturates instead of wrapping
				dist_sum = dist_sum + d;
				if (dist_sum > ACC_CEIL)
					dist_sum = ACC_CEIL;
			end
			if (!held_live || dist_sum >= spc || p.is_corner) begin
				if (held_live)
					emit_held(1'b0);
				hold_point(p);
				held_live = 1'b1;
				dist_sum = 0;
			end else if (2 * d < spc && (p.stability > held_stab ||
					20 * int'(p.grad_mag) > 23 * int'(held_grad))) begin
				// nearby and better: swap in place, no beat
				hold_point(p);
			end
		end
		// chain end flushes even when this point was skipped
		if (p.chain_end) begin
			if (held_live)
				emit_held(1'b1);
			held_live = 1'b0;
			dist_sum = 0;
			seq_count = 0;
		end
	endtask

	// ---------------------------------------------------------------
	// Point channel driver
	// n_typed < 0: take the shadow's results; else the typed-in ones
	// ---------------------------------------------------------------
	task automatic send_point(input in_t p, input int n_typed, input out_t res_a,
			input out_t res_b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			snd_calm = !snd_calm;
		gap = snd_calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (!point_ready);
		thin_point(p);
		if (n_typed < 0) begin
			for (int i = 0; i < fresh_n; i++)
				owe_beat(fresh_kept[i]);
		end else begin
			if (n_typed > 0)
				owe_beat(res_a);
			if (n_typed > 1)
				owe_beat(res_b);
		end
	endtask

	// drop valid, wait for every owed beat, then let the pipe empty out
	task automatic settle();
		@(negedge clk);
		point_valid <= 1'b0;
		while (pending_kept.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of spacing_q4 followed by a read-back
	task automatic write_spacing(input logic [COORD_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_SPACING);
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		spacing_reg = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[COORD_W-1:0] !== v) begin
			$display("%0t spacing_q4 read-back: expected %0h, got %0h", $time, v, rd);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------
	// Random stimulus
	// ---------------------------------------------------------------

	// a walk along a chain with random step size; a few chains never close
	task automatic random_chain(input int len);
		in_t p;
		int x;
		int y;
		int step;
		int dx;
		int dy;
		logic [IDX_W-1:0] idx;
		bit closes;
		x = $urandom_range(0, 65535);
		y = $urandom_range(0, 65535);
		idx = IDX_W'($urandom);
		case ($urandom_range(0, 7))
			0: step = 65535;
			1: step = 2 * eff_spacing();
			2, 3: step = eff_spacing() / 4;
			default: step = eff_spacing() / 2;
		endcase
		if (step > 65535)
			step = 65535;
		closes = ($urandom_range(0, 7) != 0);
		for (int k = 0; k < len; k++) begin
			dx = $urandom_range(0, step);
			dy = $urandom_range(0, step);
			x = ($urandom_range(0, 1) ? x + dx : x - dx) & 16'hFFFF;
			y = ($urandom_range(0, 1) ? y + dy : y - dy) & 16'hFFFF;
			p.pos_x       = x[COORD_W-1:0];
			p.pos_y       = y[COORD_W-1:0];
			p.is_stable   = ($urandom_range(0, 9) != 0);
			p.is_corner   = ($urandom_range(0, 15) == 0);
			p.stability   = ($urandom_range(0, 7) == 0) ? STAB_W'($urandom_range(0, 2047))
					: STAB_W'($urandom_range(0, 1024));
			p.grad_mag    = GRAD_W'($urandom);
			p.point_index = idx;
			p.chain_end   = closes && (k == len - 1);
			idx++;
			send_point(p, -1, '0, '0);
		end
	endtask

	task automatic random_phase(input int budget);
		int done;
		int len;
		logic [95:0] raw;
		done = 0;
		while (done < budget) begin
			if ($urandom_range(0, 4) == 0) begin
				// noise: every field and bit fully random
				len = $urandom_range(1, 3);
				for (int k = 0; k < len; k++) begin
					raw = {$urandom, $urandom, $urandom};
					send_point(raw[IN_W-1:0], -1, '0, '0);
				end
			end else begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60)
						: $urandom_range(1, 12);
				random_chain(len);
			end
			done += len;
		end
	endtask

	// ---------------------------------------------------------------
	// Directed rows
	// ---------------------------------------------------------------
	typedef struct {
		in_t  pt;
		int   n_typed;
		out_t res_a;
		out_t res_b;
	} dir_row_t;

	function automatic in_t pt_of(input int x, input int y, input bit st, input bit cr,
			input int stab, input int grad, input int idx, input bit ce);
		in_t p;
		p.pos_x       = COORD_W'(x);
		p.pos_y       = COORD_W'(y);
		p.is_stable   = st;
		p.is_corner   = cr;
		p.stability   = STAB_W'(stab);
		p.grad_mag    = GRAD_W'(grad);
		p.point_index = IDX_W'(idx);
		p.chain_end   = ce;
		return p;
	endfunction

	function automatic out_t res_of(input int idx, input int x, input int y, input int sq,
			input bit last);
		out_t r;
		r.kept_index    = IDX_W'(idx);
		r.kept_x        = COORD_W'(x);
		r.kept_y        = COORD_W'(y);
		r.out_seq       = IDX_W'(sq);
		r.last_of_chain = last;
		return r;
	endfunction

	function automatic dir_row_t row(input in_t p, input int n, input out_t a, input out_t b);
		dir_row_t r;
		r.pt = p;
		r.n_typed = n;
		r.res_a = a;
		r.res_b = b;
		return r;
	endfunction

	dir_row_t dir_rows [14];

	// ---------------------------------------------------------------
	// Kept channel: random stalls, check every beat against the oldest owed one
	// ---------------------------------------------------------------
	task automatic match_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t kept.%s: expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		out_t want;
		int stall;
		kept_ready = 1'b0;
		rcv_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rcv_calm = !rcv_calm;
			stall = rcv_calm ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (stall > 0) begin
				kept_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			kept_ready <= 1'b1;
			do @(posedge clk); while (!kept_valid);
			if (pending_kept.size() == 0) begin
				$display("%0t kept beat with none outstanding: expected nothing, got %h",
						$time, kept);
				errors++;
			end else begin
				want = pending_kept.pop_front();
				match_field("kept_index", want.kept_index, kept.kept_index);
				match_field("kept_x", want.kept_x, kept.kept_x);
				match_field("kept_y", want.kept_y, kept.kept_y);
				match_field("out_seq", want.out_seq, kept.out_seq);
				match_field("last_of_chain", want.last_of_chain, kept.last_of_chain);
			end
		end
	end

	// hang detector: any beat or config access counts as progress
	int unsigned quiet;
	initial quiet = 0;
	always @(posedge clk) begin
		if ((point_valid && point_ready) || (kept_valid && kept_ready) || psel) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("[edge_chain_point_decimator_unit] ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned phase_spacing [10];
		point_valid = 1'b0;
		point = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		errors = 0;
		snd_calm = 1'b0;
		spacing_reg = SPACING_RESET;
		held_x = '0;
		held_y = '0;
		held_stab = '0;
		held_grad = '0;
		held_idx = '0;
		held_live = 1'b0;
		dist_sum = 0;
		seq_count = 0;

		// reset spacing is 3.0 px (48); typed results follow by hand
		// first point of a chain: held, nothing out
		dir_rows[0]  = row(pt_of(0, 0, 1, 0, 0, 0, 0, 0), 0, '0, '0);
		// opposite corner of the image: distance far past spacing, all-ones position, gradient and index
		dir_rows[1]  = row(pt_of(16'hFFFF, 16'hFFFF, 1, 0, 1024, 16'hFFFF, 12'hFFF, 0),
				1, res_of(0, 0, 0, 0, 0), '0);
		// unstable last point still flushes the held one
		dir_rows[2]  = row(pt_of(16'h1234, 16'hABCD, 0, 1, 2047, 16'h8000, 12'h800, 1),
				1, res_of(12'hFFF, 16'hFFFF, 16'hFFFF, 1, 1), '0);
		// chain end with nothing held: silent
		dir_rows[3]  = row(pt_of(16'h0F0F, 16'hF0F0, 0, 0, 77, 99, 12'h123, 1), 0, '0, '0);
		// one-point chain: kept and flushed at once
		dir_rows[4]  = row(pt_of(16'h1234, 16'h5678, 1, 0, 300, 400, 12'h055, 1),
				1, res_of(12'h055, 16'h1234, 16'h5678, 0, 1), '0);
		dir_rows[5]  = row(pt_of(100, 100, 1, 0, 500, 1000, 1, 0), 0, '0, '0);
		// close and more stable: replaces held
		dir_rows[6]  = row(pt_of(110, 100, 1, 0, 600, 1000, 2, 0), -1, '0, '0);
		// close, gradient above 1.15x: replaces held
		dir_rows[7]  = row(pt_of(115, 100, 1, 0, 100, 1200, 3, 0), -1, '0, '0);
		// gradient exactly 1.15x, equal stability: stays
		dir_rows[8]  = row(pt_of(118, 100, 1, 0, 100, 1380, 4, 0), -1, '0, '0);
		// corner forces a keep well under the spacing
		dir_rows[9]  = row(pt_of(119, 100, 1, 1, 0, 0, 5, 0),
				1, res_of(3, 115, 100, 0, 0), '0);
		dir_rows[10] = row(pt_of(119, 160, 1, 0, 0, 0, 6, 0),
				1, res_of(5, 119, 100, 1, 0), '0);
		dir_rows[11] = row(pt_of(119, 180, 1, 0, 1000, 0, 7, 0), -1, '0, '0);
		// stability above 1.0 compared raw
		dir_rows[12] = row(pt_of(119, 200, 1, 0, 2047, 0, 8, 0), -1, '0, '0);
		// keep on the last point: two beats
		dir_rows[13] = row(pt_of(119, 230, 1, 0, 0, 0, 9, 1),
				2, res_of(8, 119, 200, 2, 0), res_of(9, 119, 230, 3, 1));

		// spacing per random phase; extremes, below-1.0 values, then random ones
		phase_spacing = '{0, 65535, 15, 1, 17, 48, 100, 16, 0, 0};
		phase_spacing[8] = $urandom_range(16, 2000);
		phase_spacing[9] = $urandom_range(0, 65535);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_point(dir_rows[i].pt, dir_rows[i].n_typed, dir_rows[i].res_a,
					dir_rows[i].res_b);
		settle();

		foreach (phase_spacing[i]) begin
			write_spacing(COORD_W'(phase_spacing[i]));
			random_phase(RANDOM_PER_PHASE);
			settle();
		end

		if (errors == 0)
			$display("[edge_chain_point_decimator_unit] OK");
		else
			$display("[edge_chain_point_decimator_unit] ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/dcd_pkg.sv
rtl/dcd_isqrt.sv
rtl/dcd_out_fifo.sv
rtl/edge_chain_point_decimator_unit.sv
verif/tb.sv
